### sv/lzbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbh_pkg
// Shared types, constants and the word generator of the lazy Zobrist hasher.
// ----------------------------------------------------------------------------
package lzbh_pkg;

  // Field widths of the channels and the register
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned COORD_W = 4;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ROWS_W  = 5;
  localparam int unsigned HASH_W  = 32;
  // column * rows + row stays below 512
  localparam int unsigned SQ_W    = 9;

  // Defaults of the top-level parameters
  localparam int unsigned SQUARES_DEF      = 256;
  localparam int unsigned PIECE_BITS_DEF   = 8;
  localparam int unsigned DEPTH_LEVELS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 5'd8;
  localparam logic [HASH_W-1:0] BLACK_XOR  = 32'hCAFE_F00D;
  localparam logic [HASH_W-1:0] SEED_RESET = 32'h00DE_C0DE;
  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  // Input selector codes; the fourth code is unused
  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEGIN  = 2'd0,
    FUNC_PIECE  = 2'd1,
    FUNC_FINISH = 2'd2
  } func_e;

  // Classified operations passed from front to back
  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_PIECE,
    OP_SKIP,
    OP_FINISH
  } op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DEPTH,
    S_PIECE
  } state_e;

  // One queued operation
  typedef struct packed {
    op_e               op;
    logic              is_black;
    logic [DEPTH_W-1:0] search_depth;
    logic [SQ_W-1:0]   sq;
    logic [CODE_W-1:0] piece_code;
  } entry_t;

  // One xorshift32 step
  function automatic logic [HASH_W-1:0] xorshift32(input logic [HASH_W-1:0] s);
    logic [HASH_W-1:0] t;
    t = s ^ (s << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return t;
  endfunction

endpackage

### sv/lzbh_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbh_in_if
// Input channel: one board item per transfer.
// ----------------------------------------------------------------------------
interface lzbh_in_if;
  import lzbh_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [DEPTH_W-1:0] search_depth;
  logic               is_black;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [CODE_W-1:0]  piece_code;

  modport source (
    output valid, func, search_depth, is_black, column, row, piece_code,
    input  ready
  );
  modport sink (
    input  valid, func, search_depth, is_black, column, row, piece_code,
    output ready
  );
endinterface

### sv/lzbh_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbh_out_if
// Output channel: one finished hash per transfer.
// ----------------------------------------------------------------------------
interface lzbh_out_if;
  import lzbh_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash;
  logic              index_error;

  modport source (output valid, hash, index_error, input ready);
  modport sink   (input valid, hash, index_error, output ready);
endinterface

### sv/lzbh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbh_front
// Accepts items, computes the square index and range checks, queues ops.
// ----------------------------------------------------------------------------
module lzbh_front #(
  parameter int unsigned SQUARES    = lzbh_pkg::SQUARES_DEF,
  parameter int unsigned PIECE_BITS = lzbh_pkg::PIECE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lzbh_in_if.sink                     in_i,
  input  logic                        cfg_we_i,
  input  logic [lzbh_pkg::ROWS_W-1:0] cfg_wdata_i,
  input  logic                        q_full_i,
  input  logic                        clearing_i,
  output logic                        push_o,
  output lzbh_pkg::entry_t            push_data_o
);
  import lzbh_pkg::*;

  logic [ROWS_W-1:0] rows_q;
  logic [SQ_W-1:0]   sq;
  logic              sq_ok;
  logic              code_ok;
  logic              accept;

  // Hold the board row count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      rows_q <= cfg_wdata_i;
    end
  end

  // Square index and range checks
  assign sq      = SQ_W'(in_i.column) * SQ_W'(rows_q) + SQ_W'(in_i.row);
  assign sq_ok   = 32'(sq) < 32'(SQUARES);
  assign code_ok = 32'(in_i.piece_code) < (32'd1 << PIECE_BITS);

  // Stall while the queue is full or the piece table is being cleared
  assign in_i.ready = !q_full_i && !clearing_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the transfer; drop the unused selector
  always_comb begin
    push_o                   = 1'b0;
    push_data_o.op           = OP_FINISH;
    push_data_o.is_black     = in_i.is_black;
    push_data_o.search_depth = in_i.search_depth;
    push_data_o.sq           = sq;
    push_data_o.piece_code   = in_i.piece_code;
    case (func_e'(in_i.func))
      FUNC_BEGIN: begin
        push_o         = accept;
        push_data_o.op = OP_BEGIN;
      end
      FUNC_PIECE: begin
        push_o         = accept;
        push_data_o.op = (sq_ok && code_ok) ? OP_PIECE : OP_SKIP;
      end
      FUNC_FINISH: begin
        push_o         = accept;
        push_data_o.op = OP_FINISH;
      end
      default: push_o = 1'b0;
    endcase
  end

endmodule

### sv/lzbh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbh_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module lzbh_queue #(
  parameter int unsigned DEPTH = lzbh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lzbh_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lzbh_pkg::entry_t head_o
);
  import lzbh_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            slots_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = count_q == CntW'(DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = slots_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

endmodule

### sv/lzbh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbh_back
// Executes queued ops: table lookups, lazy word draws, running hash, result.
// ----------------------------------------------------------------------------
module lzbh_back #(
  parameter int unsigned SQUARES      = lzbh_pkg::SQUARES_DEF,
  parameter int unsigned PIECE_BITS   = lzbh_pkg::PIECE_BITS_DEF,
  parameter int unsigned DEPTH_LEVELS = lzbh_pkg::DEPTH_LEVELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lzbh_pkg::entry_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             clearing_o,
  lzbh_out_if.source       out_o
);
  import lzbh_pkg::*;

  localparam int unsigned PieceEntries = SQUARES << PIECE_BITS;
  localparam int unsigned AddrW        = $clog2(PieceEntries);
  localparam int unsigned DepthW       = (DEPTH_LEVELS > 1) ? $clog2(DEPTH_LEVELS) : 1;

  // Piece table address of a queued op
  function automatic logic [AddrW-1:0] piece_addr(input entry_t e);
    return AddrW'((32'(e.sq) << PIECE_BITS) | 32'(e.piece_code));
  endfunction

  state_e               st_q, st_d;
  logic [AddrW-1:0]     clr_cnt_q;
  entry_t               cur_q;
  logic [HASH_W-1:0]    seed_q;
  logic [HASH_W-1:0]    hash_q;
  logic                 err_q;
  logic                 out_valid_q;
  logic [HASH_W-1:0]    out_hash_q;
  logic                 out_err_q;
  logic [DEPTH_LEVELS-1:0] dvld_q;
  logic [HASH_W-1:0]    dmem [DEPTH_LEVELS];
  logic [HASH_W:0]      pmem [PieceEntries];
  logic [HASH_W-1:0]    drd_q;
  logic [HASH_W:0]      prd_q;

  logic [HASH_W-1:0]    rng_next;
  logic [DepthW-1:0]    cur_didx;
  logic [DepthW-1:0]    head_didx;
  logic                 head_depth_ok;
  logic                 out_free;
  logic                 clr_last;
  logic                 pop;
  logic                 draw;
  logic                 dmem_we;
  logic                 pmem_we;
  logic [AddrW-1:0]     pmem_waddr;
  logic [HASH_W:0]      pmem_wdata;
  logic [HASH_W-1:0]    black_mask;

  assign rng_next      = xorshift32(seed_q);
  assign cur_didx      = DepthW'(cur_q.search_depth);
  assign head_didx     = DepthW'(head_i.search_depth);
  assign head_depth_ok = 32'(head_i.search_depth) < 32'(DEPTH_LEVELS);
  assign out_free      = !out_valid_q || out_o.ready;
  assign clr_last      = clr_cnt_q == AddrW'(PieceEntries - 1);
  assign black_mask    = head_i.is_black ? BLACK_XOR : '0;

  assign clearing_o        = st_q == S_CLEAR;
  assign pop_o             = pop;
  assign out_o.valid       = out_valid_q;
  assign out_o.hash        = out_hash_q;
  assign out_o.index_error = out_err_q;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_CLEAR: begin
        if (clr_last) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (pop && head_i.op == OP_BEGIN && head_depth_ok) st_d = S_DEPTH;
        else if (pop && head_i.op == OP_PIECE)             st_d = S_PIECE;
      end
      S_DEPTH: st_d = S_IDLE;
      S_PIECE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // State outputs: pops, table writes, word draws
  always_comb begin
    pop        = 1'b0;
    draw       = 1'b0;
    dmem_we    = 1'b0;
    pmem_we    = 1'b0;
    pmem_waddr = clr_cnt_q;
    pmem_wdata = '0;
    case (st_q)
      S_CLEAR: pmem_we = 1'b1;
      S_IDLE:  pop = !empty_i && (head_i.op != OP_FINISH || out_free);
      S_DEPTH: begin
        dmem_we = !dvld_q[cur_didx];
        draw    = !dvld_q[cur_didx];
      end
      S_PIECE: begin
        pmem_we    = !prd_q[HASH_W];
        pmem_waddr = piece_addr(cur_q);
        pmem_wdata = {1'b1, rng_next};
        draw       = !prd_q[HASH_W];
      end
      default: pop = 1'b0;
    endcase
  end

  // Piece table: clear sweep and lazy fills, registered read on pop
  always_ff @(posedge clk_i) begin
    if (pmem_we) begin
      pmem[pmem_waddr] <= pmem_wdata;
    end
    if (pop) begin
      prd_q <= pmem[piece_addr(head_i)];
    end
  end

  // Depth table words, registered read on pop
  always_ff @(posedge clk_i) begin
    if (dmem_we) begin
      dmem[cur_didx] <= rng_next;
    end
    if (pop) begin
      drd_q <= dmem[head_didx];
    end
  end

  // Hold the current op and load the result register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= head_i;
    end
    if (pop && head_i.op == OP_FINISH) begin
      out_hash_q <= hash_q;
      out_err_q  <= err_q;
    end
  end

  // Control state, generator seed and running hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      clr_cnt_q   <= '0;
      seed_q      <= SEED_RESET;
      hash_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      dvld_q      <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (draw) begin
        seed_q <= rng_next;
      end
      if (dmem_we) begin
        dvld_q[cur_didx] <= 1'b1;
      end
      // Release the result on transfer, load it on finish
      if (pop && head_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // Update the running hash and error flag
      if (pop && head_i.op == OP_BEGIN) begin
        err_q <= !head_depth_ok;
        if (!head_depth_ok) hash_q <= black_mask;
      end else if (pop && head_i.op == OP_SKIP) begin
        err_q <= 1'b1;
      end else if (st_q == S_DEPTH) begin
        hash_q <= (dvld_q[cur_didx] ? drd_q : rng_next) ^
                  (cur_q.is_black ? BLACK_XOR : '0);
      end else if (st_q == S_PIECE) begin
        hash_q <= hash_q ^ (prd_q[HASH_W] ? prd_q[HASH_W-1:0] : rng_next);
      end
    end
  end

  a_seed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_q != '0)
    else $error("generator seed reached zero");

  a_draw_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw |=> seed_q != $past(seed_q))
    else $error("word draw did not advance the seed");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_i.op == OP_FINISH) |=> out_o.valid && out_o.hash == $past(hash_q))
    else $error("finish did not present the running hash");

endmodule

### sv/lazy_zobrist_board_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_zobrist_board_hash_top
// Lazy Zobrist board hasher with an xorshift32 word generator.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per transfer: begin (depth, side to move), add
//   piece (column, row, code) or finish. Only finish produces a transfer on
//   out_o: the running hash and the index error flag since the last begin.
//   cfg_we_i/cfg_wdata_i write the board row count; write it only when idle.
// Timing:
//   The front end queues an item in the cycle it is transferred. The back
//   end takes one op per cycle for finish (while the result register can
//   take it) and out-of-range items; begin and valid pieces add a second
//   state (registered table read, then a possible word draw and write-back).
//   A finish result appears in the cycle after the back end takes it.
// Reset:
//   After reset the piece table is swept once to clear its valid bits,
//   covering SQUARES << PIECE_BITS entries (65536 at defaults); in_i.ready
//   stays low meanwhile. Register writes are taken during the sweep.
// Stall:
//   A held result stops the back end once the next finish reaches the queue
//   head; ops ahead of it still complete, then the queue fills and
//   in_i.ready drops until the result is transferred.
// ----------------------------------------------------------------------------
module lazy_zobrist_board_hash_top #(
  parameter int unsigned SQUARES      = lzbh_pkg::SQUARES_DEF,
  parameter int unsigned PIECE_BITS   = lzbh_pkg::PIECE_BITS_DEF,
  parameter int unsigned DEPTH_LEVELS = lzbh_pkg::DEPTH_LEVELS_DEF,
  parameter int unsigned QUEUE_DEPTH  = lzbh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lzbh_in_if.sink                     in_i,
  lzbh_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [lzbh_pkg::ROWS_W-1:0] cfg_wdata_i
);
  import lzbh_pkg::*;

  logic   push;
  entry_t push_data;
  logic   q_full;
  logic   q_empty;
  logic   pop;
  entry_t head;
  logic   clearing;

  // Accept and classify
  lzbh_front #(
    .SQUARES    (SQUARES),
    .PIECE_BITS (PIECE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouple front and back
  lzbh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // Execute
  lzbh_back #(
    .SQUARES      (SQUARES),
    .PIECE_BITS   (PIECE_BITS),
    .DEPTH_LEVELS (DEPTH_LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

endmodule
